// ----- src/sbcd_pkg.sv -----
// ----------------------------------------------------------------------------
// sbcd_pkg
// Types, selector codes, status codes and width helpers for the counter bank.
// ----------------------------------------------------------------------------
package sbcd_pkg;

    localparam int unsigned NUM_CNT = 12;

    // counter selectors
    localparam logic [3:0] SEL_ICOUNT      = 4'd0;
    localparam logic [3:0] SEL_IFREE       = 4'd1;
    localparam logic [3:0] SEL_FREE_BLOCKS = 4'd2;
    localparam logic [3:0] SEL_FREE_RT     = 4'd3;
    localparam logic [3:0] SEL_DBLOCKS     = 4'd4;
    localparam logic [3:0] SEL_AGCOUNT     = 4'd5;
    localparam logic [3:0] SEL_IMAX_PCT    = 4'd6;
    localparam logic [3:0] SEL_REXTSIZE    = 4'd7;
    localparam logic [3:0] SEL_RBMBLOCKS   = 4'd8;
    localparam logic [3:0] SEL_RBLOCKS     = 4'd9;
    localparam logic [3:0] SEL_REXTENTS    = 4'd10;
    localparam logic [3:0] SEL_REXTSLOG    = 4'd11;
    localparam logic [3:0] SEL_RESERVE     = 4'd12;

    // result status
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_INVALID = 2'd1;
    localparam logic [1:0] ST_NOSPACE = 2'd2;

    // configuration register indexes
    localparam logic CFG_SET_ASIDE     = 1'b0;
    localparam logic CFG_RESERVE_TOTAL = 1'b1;

    // item modes
    localparam logic MODE_ADD  = 1'b0;
    localparam logic MODE_LOAD = 1'b1;

    typedef logic [63:0] t_word;

    typedef struct packed {
        logic       mode;
        logic [3:0] counter_select;
        t_word      delta_or_value;
        logic       allow_reserve;
    } t_item;

    typedef struct packed {
        logic       cnt_we;
        t_word      cnt_value;
        t_word      reserve_left;
        logic [1:0] status;
        t_word      shown;
    } t_upd;

    typedef struct packed {
        logic [1:0]  status;
        logic [62:0] counter_value;
        logic [62:0] reserve_available;
    } t_res;

    // 32-bit and 8-bit counters take the narrow add path
    function automatic logic is_narrow(input logic [3:0] sel);
        logic r;
        case (sel)
            SEL_AGCOUNT, SEL_IMAX_PCT, SEL_REXTSIZE,
            SEL_RBMBLOCKS, SEL_REXTSLOG: r = 1'b1;
            default:                     r = 1'b0;
        endcase
        return r;
    endfunction

    function automatic t_word cnt_mask(input logic [3:0] sel);
        t_word m;
        case (sel)
            SEL_AGCOUNT, SEL_REXTSIZE, SEL_RBMBLOCKS: m = {32'd0, 32'hFFFF_FFFF};
            SEL_IMAX_PCT, SEL_REXTSLOG:               m = {56'd0, 8'hFF};
            default:                                  m = '1;
        endcase
        return m;
    endfunction

endpackage

// ----- src/sbcd_in_if.sv -----
// ----------------------------------------------------------------------------
// sbcd_in_if
// Input channel of the counter bank: valid/ready with one update item.
// ----------------------------------------------------------------------------
interface sbcd_in_if;
    logic        valid;
    logic        ready;
    logic        mode;
    logic [3:0]  counter_select;
    logic signed [63:0] delta_or_value;
    logic        allow_reserve;

    modport source (
        output valid, mode, counter_select, delta_or_value, allow_reserve,
        input  ready
    );
    modport sink (
        input  valid, mode, counter_select, delta_or_value, allow_reserve,
        output ready
    );
endinterface

// ----- src/sbcd_out_if.sv -----
// ----------------------------------------------------------------------------
// sbcd_out_if
// Result channel of the counter bank: valid/ready with one result item.
// ----------------------------------------------------------------------------
interface sbcd_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [62:0] counter_value;
    logic [62:0] reserve_available;

    modport source (
        output valid, status, counter_value, reserve_available,
        input  ready
    );
    modport sink (
        input  valid, status, counter_value, reserve_available,
        output ready
    );
endinterface

// ----- src/sbcd_update.sv -----
// ----------------------------------------------------------------------------
// sbcd_update
// Next-state logic for one item: load, signed add with underflow refusal,
// and the free-block path that trades with the reserve pool.
// ----------------------------------------------------------------------------
module sbcd_update (
    input  sbcd_pkg::t_item i_item,
    input  sbcd_pkg::t_word i_cur,
    input  sbcd_pkg::t_word i_reserve_left,
    input  logic [31:0]     i_set_aside,
    input  logic [62:0]     i_reserve_total,
    output sbcd_pkg::t_upd  o_upd
);
    import sbcd_pkg::*;

    t_word       val;
    t_word       sum64;
    logic [31:0] sum32;
    t_word       rl_sum;
    t_word       net;
    t_word       net_sum;
    t_word       used;
    t_word       fb_over;
    t_word       mask;
    logic        delta_pos;
    logic        used_gt;
    logic        known;

    assign val       = i_item.delta_or_value;
    assign sum64     = i_cur + val;
    assign sum32     = i_cur[31:0] + val[31:0];
    assign rl_sum    = i_reserve_left + val;
    assign net       = i_cur - {32'd0, i_set_aside};
    assign net_sum   = net + val;
    assign used      = {1'b0, i_reserve_total} - i_reserve_left;
    // counter after refilling the pool: cur + delta - used
    assign fb_over   = sum64 - used;
    assign mask      = cnt_mask(i_item.counter_select);
    assign delta_pos = !val[63] && (val != '0);
    assign used_gt   = $signed(used) > $signed(val);
    assign known     = i_item.counter_select < 4'(NUM_CNT);

    always_comb begin
        o_upd.cnt_we       = 1'b0;
        o_upd.cnt_value    = i_cur;
        o_upd.reserve_left = i_reserve_left;
        o_upd.status       = ST_OK;
        o_upd.shown        = '0;

        if (i_item.counter_select == SEL_RESERVE) begin
            if (i_item.mode == MODE_LOAD) begin
                o_upd.reserve_left = val;
            end else if (rl_sum[63]) begin
                o_upd.status = ST_INVALID;
            end else begin
                o_upd.reserve_left = rl_sum;
            end
            o_upd.shown = o_upd.reserve_left;
        end else if (known) begin
            if (i_item.mode == MODE_LOAD) begin
                o_upd.cnt_we    = 1'b1;
                o_upd.cnt_value = val & mask;
            end else if (i_item.counter_select == SEL_FREE_BLOCKS) begin
                if (delta_pos) begin
                    // returned blocks refill the pool first
                    if (used_gt) begin
                        o_upd.reserve_left = rl_sum;
                    end else begin
                        o_upd.reserve_left = {1'b0, i_reserve_total};
                        o_upd.cnt_we       = 1'b1;
                        o_upd.cnt_value    = fb_over;
                    end
                end else if (!net_sum[63]) begin
                    o_upd.cnt_we    = 1'b1;
                    o_upd.cnt_value = sum64;
                end else if (!i_item.allow_reserve) begin
                    o_upd.status = ST_NOSPACE;
                end else if (!rl_sum[63]) begin
                    o_upd.reserve_left = rl_sum;
                end else begin
                    o_upd.status = ST_NOSPACE;
                end
            end else if (!is_narrow(i_item.counter_select)) begin
                if (sum64[63]) begin
                    o_upd.status = (i_item.counter_select == SEL_FREE_RT) ?
                                   ST_NOSPACE : ST_INVALID;
                end else begin
                    o_upd.cnt_we    = 1'b1;
                    o_upd.cnt_value = sum64;
                end
            end else if (sum32[31]) begin
                o_upd.status = ST_INVALID;
            end else begin
                o_upd.cnt_we    = 1'b1;
                o_upd.cnt_value = {32'd0, sum32} & mask;
            end
            o_upd.shown = o_upd.cnt_we ? o_upd.cnt_value : i_cur;
        end else begin
            o_upd.status = ST_INVALID;
        end
    end

endmodule

// ----- src/sb_counter_delta_reserve.sv -----
// ----------------------------------------------------------------------------
// sb_counter_delta_reserve
// Bank of twelve file-system counters plus a reserve-pool count, updated
// by load or signed-add items.
// ----------------------------------------------------------------------------
// Path: an accepted item is held in the input register, then passes through
//   the update logic into the result register and counter state.
// Throughput: one item per cycle while the result channel does not stall;
//   state an item writes is seen by the next, both reading the same registers.
// Reset: clears counters, reserve pool, configuration and both stages.
module sb_counter_delta_reserve (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [62:0] i_cfg_data,
    sbcd_in_if.sink     i_in,
    sbcd_out_if.source  o_out
);
    import sbcd_pkg::*;

    logic        r_in_valid;
    t_item       r_item;
    logic        r_out_valid;
    t_res        r_res;
    t_word       r_counters [NUM_CNT];
    t_word       r_reserve_left;
    logic [31:0] r_set_aside;
    logic [62:0] r_reserve_total;

    logic  advance;
    logic  in_take;
    t_word cur;
    t_upd  upd;
    t_res  n_res;

    assign advance    = r_in_valid && (!r_out_valid || o_out.ready);
    assign in_take    = i_in.valid && i_in.ready;
    assign i_in.ready = !r_in_valid || advance;

    assign cur = (r_item.counter_select < 4'(NUM_CNT)) ?
                 r_counters[r_item.counter_select] : '0;

    sbcd_update u_update (
        .i_item         (r_item),
        .i_cur          (cur),
        .i_reserve_left (r_reserve_left),
        .i_set_aside    (r_set_aside),
        .i_reserve_total(r_reserve_total),
        .o_upd          (upd)
    );

    assign n_res.status            = upd.status;
    assign n_res.counter_value     = upd.shown[62:0];
    assign n_res.reserve_available = upd.reserve_left[62:0];

    // control, configuration and counter state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid      <= 1'b0;
            r_out_valid     <= 1'b0;
            r_set_aside     <= '0;
            r_reserve_total <= '0;
            r_reserve_left  <= '0;
            r_counters      <= '{default: '0};
        end else begin
            if (i_in.ready) begin
                r_in_valid <= i_in.valid;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_SET_ASIDE:     r_set_aside     <= i_cfg_data[31:0];
                    CFG_RESERVE_TOTAL: r_reserve_total <= i_cfg_data;
                    default:           r_set_aside     <= r_set_aside;
                endcase
            end
            if (advance) begin
                r_reserve_left <= upd.reserve_left;
                if (upd.cnt_we) begin
                    r_counters[r_item.counter_select] <= upd.cnt_value;
                end
            end
        end
    end

    // payload: hold while stalled
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_item.mode           <= i_in.mode;
            r_item.counter_select <= i_in.counter_select;
            r_item.delta_or_value <= i_in.delta_or_value;
            r_item.allow_reserve  <= i_in.allow_reserve;
        end
        if (advance) begin
            r_res <= n_res;
        end
    end

    assign o_out.valid             = r_out_valid;
    assign o_out.status            = r_res.status;
    assign o_out.counter_value     = r_res.counter_value;
    assign o_out.reserve_available = r_res.reserve_available;

    // unknown selector always reports invalid
    a_unknown_sel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && (r_item.counter_select > SEL_RESERVE) |=> o_out.status == ST_INVALID)
        else $error("unknown selector did not give invalid status");

    // a refused step leaves the reserve pool alone
    a_refuse_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && (upd.status != ST_OK) |=> $stable(r_reserve_left))
        else $error("refused step changed the reserve pool");

    // a held input item is never dropped
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !advance |=> r_in_valid)
        else $error("input stage lost an item");

endmodule
